@@ design/kbc_pkg.sv @@
// ----------------------------------------------------------------------------
// kbc_pkg
// Types, constants and symbol table functions for the keyed six-bit codec.
// ----------------------------------------------------------------------------
package kbc_pkg;

  localparam int MAX_KEY_CHARS = 8;
  localparam int CHAR_W        = 8;
  localparam int KEY_W         = MAX_KEY_CHARS * CHAR_W;
  localparam int KPOS_W        = 3;
  localparam int KLEN_W        = 4;
  localparam int SYM_W         = 6;
  localparam int REG_IDX_W     = 2;
  localparam int FIFO_DEPTH    = 4;
  localparam int FIFO_PTR_W    = 2;
  localparam int FIFO_CNT_W    = 3;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_KEY_CHARS    = 2'd0,
    REG_KEY_LENGTH   = 2'd1,
    REG_KEY_SUBTRACT = 2'd2
  } kbc_reg_t;

  typedef enum logic {
    FUNC_ENCODE = 1'b0,
    FUNC_DECODE = 1'b1
  } kbc_func_t;

  typedef struct packed {
    logic              func;
    logic [CHAR_W-1:0] data_in;
    logic              last_item;
  } kbc_in_t;

  typedef struct packed {
    logic [CHAR_W-1:0] data_out;
    logic              last_out;
    logic              error;
  } kbc_out_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key_chars;
    logic [KLEN_W-1:0] key_length;
    logic              key_subtract;
  } kbc_cfg_t;

  typedef struct packed {
    logic [1:0] count;
    kbc_out_t   r0;
    kbc_out_t   r1;
  } kbc_push_t;

  typedef struct packed {
    logic             valid;
    logic [SYM_W-1:0] sym;
  } kbc_lookup_t;

  // table: 0-9, a-z, A-Z, '{', '}'
  function automatic logic [CHAR_W-1:0] kbc_sym_char(input logic [SYM_W-1:0] idx);
    logic [CHAR_W-1:0] ext;
    logic [CHAR_W-1:0] c;
    ext = {2'b00, idx};
    if (idx < 6'd10) c = 8'd48 + ext;
    else if (idx < 6'd36) c = 8'd87 + ext;
    else if (idx < 6'd62) c = 8'd29 + ext;
    else if (idx == 6'd62) c = 8'd123;
    else c = 8'd125;
    return c;
  endfunction

  function automatic kbc_lookup_t kbc_char_sym(input logic [CHAR_W-1:0] c);
    kbc_lookup_t       r;
    logic [CHAR_W-1:0] t;
    r.valid = 1'b1;
    t       = 8'd0;
    if (c >= 8'd48 && c <= 8'd57) t = c - 8'd48;
    else if (c >= 8'd97 && c <= 8'd122) t = c - 8'd87;
    else if (c >= 8'd65 && c <= 8'd90) t = c - 8'd29;
    else if (c == 8'd123) t = 8'd62;
    else if (c == 8'd125) t = 8'd63;
    else r.valid = 1'b0;
    r.sym = t[SYM_W-1:0];
    return r;
  endfunction

  function automatic logic [SYM_W-1:0] kbc_rot(input logic [SYM_W-1:0]  v,
                                               input logic [CHAR_W-1:0] k,
                                               input logic              add);
    logic [SYM_W-1:0] r;
    if (add) r = v + k[SYM_W-1:0];
    else r = v - k[SYM_W-1:0];
    return r;
  endfunction

endpackage

@@ design/kbc_stream_if.sv @@
// ----------------------------------------------------------------------------
// kbc_stream_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface kbc_stream_if #(parameter type T = logic);

  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);

endinterface

@@ design/kbc_result_fifo.sv @@
// ----------------------------------------------------------------------------
// kbc_result_fifo
// Four-entry result queue, up to two entries written per cycle, one read.
// ----------------------------------------------------------------------------
module kbc_result_fifo (
  input  logic               clk,
  input  logic               rst,
  input  kbc_pkg::kbc_push_t push,
  output logic               room,
  kbc_stream_if.source       results
);
  import kbc_pkg::*;

  kbc_out_t                entries [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]   rd_ptr;
  logic [FIFO_PTR_W-1:0]   wr_ptr;
  logic [FIFO_CNT_W-1:0]   count;
  logic                    pop;

  assign pop          = results.valid & results.ready;
  assign room         = (count <= 3'd2);
  assign results.valid = (count != '0);
  assign results.data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      wr_ptr <= wr_ptr + push.count;
      count  <= count + {1'b0, push.count} - {2'b00, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) entries[wr_ptr] <= push.r0;
    if (push.count == 2'd2) entries[wr_ptr + 1'b1] <= push.r1;
  end

endmodule

@@ design/kbc_core.sv @@
// ----------------------------------------------------------------------------
// kbc_core
// Item register, codec state and the single-pass pack/unpack logic.
// ----------------------------------------------------------------------------
module kbc_core (
  input  logic               clk,
  input  logic               rst,
  input  kbc_pkg::kbc_cfg_t  cfg,
  input  logic               room,
  output kbc_pkg::kbc_push_t push,
  kbc_stream_if.sink         items
);
  import kbc_pkg::*;

  logic              item_valid;
  kbc_in_t           item;
  logic              advance;

  logic [1:0]        phase;
  logic [SYM_W-1:0]  residue_bits;
  logic [KPOS_W-1:0] key_position;
  logic              error_seen;

  logic [1:0]        phase_next;
  logic [SYM_W-1:0]  residue_bits_next;
  logic [KPOS_W-1:0] key_position_next;
  logic              error_seen_next;

  logic [KLEN_W-1:0] len_eff;
  logic [KPOS_W-1:0] pos1;
  logic [KPOS_W-1:0] pos2;
  logic [CHAR_W-1:0] k0;
  logic [CHAR_W-1:0] k1;
  logic              enc_add;
  kbc_lookup_t       lk;
  logic              err_now;
  logic [1:0]        p;
  logic [13:0]       dw;
  logic [SYM_W-1:0]  s;
  logic [1:0]        n;
  kbc_out_t          r0;
  kbc_out_t          r1;

  function automatic logic [KPOS_W-1:0] step_pos(input logic [KPOS_W-1:0] pos,
                                                 input logic [KLEN_W-1:0] len);
    logic [KLEN_W-1:0] nxt;
    nxt = {1'b0, pos} + 4'd1;
    return (nxt >= len) ? '0 : nxt[KPOS_W-1:0];
  endfunction

  assign advance     = item_valid & room;
  assign items.ready = ~item_valid | advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (items.ready) begin
      item_valid <= items.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (items.ready && items.valid) item <= items.data;
  end

  always_comb begin
    if (cfg.key_length == '0) len_eff = 4'd1;
    else if (cfg.key_length > 4'(MAX_KEY_CHARS)) len_eff = 4'(MAX_KEY_CHARS);
    else len_eff = cfg.key_length;
    pos1    = step_pos(key_position, len_eff);
    pos2    = step_pos(pos1, len_eff);
    k0      = cfg.key_chars[CHAR_W*key_position +: CHAR_W];
    k1      = cfg.key_chars[CHAR_W*pos1 +: CHAR_W];
    enc_add = ~cfg.key_subtract;
    lk      = kbc_char_sym(item.data_in);
    err_now = error_seen | ((item.func == FUNC_DECODE) & ~lk.valid);

    phase_next        = phase;
    residue_bits_next = residue_bits;
    key_position_next = key_position;
    error_seen_next   = err_now;
    n                 = 2'd0;
    r0                = '0;
    r1                = '0;
    p                 = 2'd0;
    dw                = '0;
    s                 = '0;

    if (!err_now) begin
      if (item.func == FUNC_ENCODE) begin
        p  = (phase == 2'd3) ? 2'd0 : phase;
        dw = ({6'd0, item.data_in} << {p, 1'b0}) | {8'd0, residue_bits};
        r0.data_out       = kbc_sym_char(kbc_rot(dw[5:0], k0, enc_add));
        n                 = 2'd1;
        key_position_next = pos1;
        if (p == 2'd2) begin
          r1.data_out       = kbc_sym_char(kbc_rot(dw[11:6], k1, enc_add));
          n                 = 2'd2;
          key_position_next = pos2;
          phase_next        = 2'd0;
          residue_bits_next = '0;
        end else begin
          phase_next        = p + 2'd1;
          residue_bits_next = dw[11:6];
          if (item.last_item && dw[11:6] != '0) begin
            r1.data_out = kbc_sym_char(kbc_rot(dw[11:6], k1, enc_add));
            n           = 2'd2;
          end
        end
      end else begin
        s                 = kbc_rot(lk.sym, k0, ~enc_add);
        key_position_next = pos1;
        phase_next        = phase + 2'd1;
        case (phase)
          2'd1:    dw = {2'b00, s, 6'd0} | {8'd0, residue_bits};
          2'd2:    dw = {4'd0, s, 4'd0} | {8'd0, residue_bits};
          2'd3:    dw = {6'd0, s, 2'd0} | {8'd0, residue_bits};
          default: dw = {8'd0, s};
        endcase
        if (phase == 2'd0) begin
          residue_bits_next = s;
        end else begin
          r0.data_out       = dw[7:0];
          n                 = 2'd1;
          residue_bits_next = dw[13:8];
        end
        if (item.last_item && residue_bits_next != '0) begin
          if (phase == 2'd0) begin
            r0.data_out = {2'b00, residue_bits_next};
            n           = 2'd1;
          end else begin
            r1.data_out = {2'b00, residue_bits_next};
            n           = 2'd2;
          end
        end
      end
      if (item.last_item) begin
        if (n == 2'd1) r0.last_out = 1'b1;
        if (n == 2'd2) r1.last_out = 1'b1;
      end
    end else if (item.last_item) begin
      r0.last_out = 1'b1;
      r0.error    = 1'b1;
      n           = 2'd1;
    end

    if (item.last_item) begin
      phase_next        = 2'd0;
      residue_bits_next = '0;
      key_position_next = '0;
      error_seen_next   = 1'b0;
    end
  end

  assign push.count = advance ? n : 2'd0;
  assign push.r0    = r0;
  assign push.r1    = r1;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= '0;
      residue_bits <= '0;
      key_position <= '0;
      error_seen   <= 1'b0;
    end else if (advance) begin
      phase        <= phase_next;
      residue_bits <= residue_bits_next;
      key_position <= key_position_next;
      error_seen   <= error_seen_next;
    end
  end

endmodule

@@ design/keyed_six_bit_codec.sv @@
// ----------------------------------------------------------------------------
// keyed_six_bit_codec
// Base64-style six-bit packer/unpacker with a rotating key, top level.
// First result of an item passes the item register and the result queue.
// Throughput: one item a cycle when it yields one result and results drain;
// items yielding two results are held back by the single result channel.
// Reset: synchronous; clears codec state, queue and key registers to defaults.
// ----------------------------------------------------------------------------
module keyed_six_bit_codec (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [kbc_pkg::REG_IDX_W-1:0]        cfg_index,
  input  logic [kbc_pkg::KEY_W-1:0]            cfg_data,
  kbc_stream_if.sink                           items,
  kbc_stream_if.source                         results
);
  import kbc_pkg::*;

  kbc_cfg_t  cfg;
  kbc_push_t push;
  logic      room;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.key_chars    <= '0;
      cfg.key_length   <= 4'd1;
      cfg.key_subtract <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KEY_CHARS:    cfg.key_chars    <= cfg_data;
        REG_KEY_LENGTH:   cfg.key_length   <= cfg_data[KLEN_W-1:0];
        REG_KEY_SUBTRACT: cfg.key_subtract <= cfg_data[0];
        default:          ;
      endcase
    end
  end

  kbc_core u_core (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .room  (room),
    .push  (push),
    .items (items)
  );

  kbc_result_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .room    (room),
    .results (results)
  );

endmodule

@@ bench/kbc_codec_checker.sv @@
// ----------------------------------------------------------------------------
// kbc_codec_checker
// Watches the key port and both channels of the keyed six-bit codec. Keeps
// its own copy of the key registers and the packing state, works out the
// results of every accepted item and compares each result transaction with
// the oldest one still due. Hands back a failure count and the number of
// results still due.
// ----------------------------------------------------------------------------
module kbc_codec_checker
  import kbc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [KEY_W-1:0]     cfg_data,
  input  logic                 item_valid,
  input  logic                 item_ready,
  input  kbc_in_t              item_data,
  input  logic                 res_valid,
  input  logic                 res_ready,
  input  kbc_out_t             res_data,
  output int                   fail_count,
  output int                   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [7:0]        sym_chars [64];
  logic [KEY_W-1:0]  key_word   = '0;
  logic [KLEN_W-1:0] key_len    = 4'd1;
  logic              key_sub    = 1'b0;
  logic [1:0]        grp_phase  = 2'd0;
  logic [5:0]        carry_bits = 6'd0;
  logic [2:0]        key_idx    = 3'd0;
  logic              err_flag   = 1'b0;
  kbc_out_t          due_results [$];
  int                fails      = 0;
  int                due_count  = 0;

  assign fail_count = fails;
  assign pending    = due_count;

  initial begin
    for (int i = 0; i < 64; i++) begin
      if (i < 10) sym_chars[i] = 8'h30 + 8'(i);
      else if (i < 36) sym_chars[i] = 8'h61 + 8'(i - 10);
      else if (i < 62) sym_chars[i] = 8'h41 + 8'(i - 36);
      else if (i == 62) sym_chars[i] = 8'h7b;
      else sym_chars[i] = 8'h7d;
    end
  end

  function automatic int char_index(input logic [7:0] c);
    for (int i = 0; i < 64; i++)
      if (sym_chars[i] == c) return i;
    return -1;
  endfunction

  function automatic logic [5:0] key_turn(input logic [5:0] v, input logic add);
    logic [5:0] k;
    k = key_word[8*key_idx +: 6];
    return add ? v + k : v - k;
  endfunction

  function automatic void key_step();
    int span;
    span = (key_len == 0) ? 1 : (key_len > MAX_KEY_CHARS) ? MAX_KEY_CHARS : int'(key_len);
    key_idx = (int'(key_idx) + 1 >= span) ? 3'd0 : key_idx + 3'd1;
  endfunction

  function automatic kbc_out_t plain(input logic [7:0] d);
    return '{data_out: d, last_out: 1'b0, error: 1'b0};
  endfunction

  task automatic pack_or_unpack(input kbc_in_t it);
    kbc_out_t    outs [2];
    int          n;
    int          p;
    int          idx;
    logic [13:0] word;
    logic [5:0]  sym;
    logic        enc_add;
    n       = 0;
    word    = '0;
    enc_add = (key_sub == 1'b0);
    if (it.func == FUNC_ENCODE) begin
      if (!err_flag) begin
        p = (grp_phase == 2'd3) ? 0 : int'(grp_phase);
        word = (14'(it.data_in) << (2 * p)) | 14'(carry_bits);
        outs[n] = plain(sym_chars[key_turn(word[5:0], enc_add)]);
        n = n + 1;
        key_step();
        word = word >> 6;
        if (p == 2) begin
          outs[n] = plain(sym_chars[key_turn(word[5:0], enc_add)]);
          n = n + 1;
          key_step();
          word = '0;
          grp_phase = 2'd0;
        end else begin
          grp_phase = 2'(p + 1);
        end
        carry_bits = word[5:0];
      end
    end else begin
      idx = char_index(it.data_in);
      if (idx < 0) begin
        err_flag = 1'b1;
      end else if (!err_flag) begin
        sym = key_turn(6'(idx), !enc_add);
        key_step();
        if (grp_phase == 2'd0) begin
          word = 14'(sym);
        end else begin
          word = (14'(sym) << (2 * (4 - int'(grp_phase)))) | 14'(carry_bits);
          outs[n] = plain(word[7:0]);
          n = n + 1;
          word = word >> 8;
        end
        grp_phase = grp_phase + 2'd1;
        carry_bits = word[5:0];
      end
    end
    if (it.last_item) begin
      if (err_flag) begin
        outs[0] = '{data_out: 8'h00, last_out: 1'b0, error: 1'b1};
        n = 1;
      end else if (carry_bits != 6'd0) begin
        if (it.func == FUNC_ENCODE) outs[n] = plain(sym_chars[key_turn(carry_bits, enc_add)]);
        else outs[n] = plain({2'b00, carry_bits});
        n = n + 1;
      end
      if (n > 0) outs[n-1].last_out = 1'b1;
      grp_phase  = 2'd0;
      carry_bits = 6'd0;
      key_idx    = 3'd0;
      err_flag   = 1'b0;
    end
    for (int i = 0; i < n; i++) due_results.push_back(outs[i]);
  endtask

  always @(posedge clk) begin
    kbc_out_t want;
    if (rst) begin
      key_word   = '0;
      key_len    = 4'd1;
      key_sub    = 1'b0;
      grp_phase  = 2'd0;
      carry_bits = 6'd0;
      key_idx    = 3'd0;
      err_flag   = 1'b0;
      due_results.delete();
    end else begin
      if (cfg_we) begin
        case (kbc_reg_t'(cfg_index))
          REG_KEY_CHARS:    key_word = cfg_data;
          REG_KEY_LENGTH:   key_len  = cfg_data[KLEN_W-1:0];
          REG_KEY_SUBTRACT: key_sub  = cfg_data[0];
          default: ;
        endcase
      end
      if (res_valid && res_ready) begin
        if (due_results.size() == 0) begin
          $error("result with none due: data_out %02h last_out %0b error %0b",
                 res_data.data_out, res_data.last_out, res_data.error);
          fails++;
        end else begin
          want = due_results.pop_front();
          if (res_data.data_out !== want.data_out) begin
            $error("data_out: expected %02h, got %02h", want.data_out, res_data.data_out);
            fails++;
          end
          if (res_data.last_out !== want.last_out) begin
            $error("last_out: expected %0b, got %0b", want.last_out, res_data.last_out);
            fails++;
          end
          if (res_data.error !== want.error) begin
            $error("error: expected %0b, got %0b", want.error, res_data.error);
            fails++;
          end
        end
      end
      if (item_valid && item_ready) pack_or_unpack(item_data);
    end
    due_count = due_results.size();
  end

endmodule

@@ bench/tb_keyed_six_bit_codec.sv @@
// ----------------------------------------------------------------------------
// tb_keyed_six_bit_codec
// Drives the keyed six-bit codec with a short directed run of encode, decode,
// mixed, broken and flushed strings, then random strings under many key
// settings with bursty idling on both channels. The checker beside the block
// predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_keyed_six_bit_codec;
  timeunit 1ns;
  timeprecision 1ps;
  import kbc_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int SETTLE       = 6;
  localparam int RAND_PHASES  = 16;
  localparam int PHASE_ITEMS  = 100;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 cfg_we    = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index = '0;
  logic [KEY_W-1:0]     cfg_data  = '0;
  logic                 src_idle  = 1'b1;
  logic                 snk_idle  = 1'b1;
  int                   chk_fails;
  int                   chk_pending;
  int unsigned          cycles    = 0;

  kbc_stream_if #(.T(kbc_in_t))  items_if ();
  kbc_stream_if #(.T(kbc_out_t)) results_if ();

  keyed_six_bit_codec u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .items     (items_if),
    .results   (results_if)
  );

  kbc_codec_checker u_chk (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item_valid (items_if.valid),
    .item_ready (items_if.ready),
    .item_data  (items_if.data),
    .res_valid  (results_if.valid),
    .res_ready  (results_if.ready),
    .res_data   (results_if.data),
    .fail_count (chk_fails),
    .pending    (chk_pending)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // result side back-pressure
  initial begin
    int stall_left;
    stall_left = 0;
    results_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        results_if.ready <= 1'b0;
      end else if (snk_idle && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 8);
        results_if.ready <= 1'b0;
      end else begin
        results_if.ready <= 1'b1;
      end
    end
  end

  // called at a falling edge, returns at the falling edge after the transaction
  task automatic push_item(input kbc_func_t f, input logic [7:0] d, input logic l);
    int gap;
    gap = 0;
    if (src_idle && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 9);
    if (gap > 0) begin
      items_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    items_if.valid <= 1'b1;
    items_if.data  <= '{func: f, data_in: d, last_item: l};
    do @(posedge clk); while (!items_if.ready);
    @(negedge clk);
  endtask

  task automatic settle();
    items_if.valid <= 1'b0;
    while (chk_pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic load_key(input logic [KEY_W-1:0] key, input logic [3:0] len,
                          input logic sub);
    cfg_we    <= 1'b1;
    cfg_index <= REG_KEY_CHARS;
    cfg_data  <= key;
    @(negedge clk);
    cfg_index <= REG_KEY_LENGTH;
    cfg_data  <= KEY_W'(len);
    @(negedge clk);
    cfg_index <= REG_KEY_SUBTRACT;
    cfg_data  <= KEY_W'(sub);
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [7:0] table_char();
    return kbc_sym_char(6'($urandom_range(0, 63)));
  endfunction

  function automatic logic [7:0] stray_char();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    while (kbc_char_sym(c).valid) c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  // kinds: 0-3 encode, 4-6 decode, 7 mixed funcs, 8 decode with a stray
  // character, 9 noise that may leave the string open
  task automatic send_string(input int kind, inout int sent);
    int         len;
    int         bad_at;
    kbc_func_t  f;
    logic [7:0] c;
    logic       l;
    len    = $urandom_range(1, 10);
    bad_at = $urandom_range(0, len - 1);
    for (int i = 0; i < len; i++) begin
      l = (i == len - 1);
      if (kind <= 3) begin
        f = FUNC_ENCODE;
        c = 8'($urandom_range(0, 255));
      end else if (kind <= 6) begin
        f = FUNC_DECODE;
        c = table_char();
      end else if (kind == 7) begin
        f = kbc_func_t'($urandom_range(0, 1));
        c = (f == FUNC_ENCODE) ? 8'($urandom_range(0, 255)) : table_char();
      end else if (kind == 8) begin
        f = (i > bad_at && $urandom_range(0, 2) == 0) ? FUNC_ENCODE : FUNC_DECODE;
        c = (i == bad_at) ? stray_char() : table_char();
        if (f == FUNC_ENCODE) c = 8'($urandom_range(0, 255));
      end else begin
        f = kbc_func_t'($urandom_range(0, 1));
        c = 8'($urandom_range(0, 255));
        l = ($urandom_range(0, 3) == 0);
      end
      push_item(f, c, l);
      sent++;
    end
  endtask

  initial begin
    int          sent;
    logic [63:0] key;
    logic [3:0]  len;
    logic        sub;
    items_if.valid = 1'b0;
    items_if.data  = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset key: zero, one character, adding on encode
    push_item(FUNC_ENCODE, 8'h00, 1'b0);
    push_item(FUNC_ENCODE, 8'hFF, 1'b0);
    push_item(FUNC_ENCODE, 8'h5A, 1'b1);
    push_item(FUNC_ENCODE, 8'hFF, 1'b1);
    push_item(FUNC_DECODE, 8'h7D, 1'b0);
    push_item(FUNC_DECODE, 8'h7B, 1'b0);
    push_item(FUNC_DECODE, 8'h30, 1'b0);
    push_item(FUNC_DECODE, 8'h5A, 1'b1);
    // zero symbol at group start: last item with nothing to emit
    push_item(FUNC_DECODE, 8'h30, 1'b1);
    settle();

    // oversized length, zero characters inside the key, subtracting
    load_key(64'h003F_80FF_4100_7F01, 4'd15, 1'b1);
    push_item(FUNC_ENCODE, 8'hA5, 1'b0);
    push_item(FUNC_DECODE, 8'h61, 1'b0);
    push_item(FUNC_ENCODE, 8'h3C, 1'b0);
    push_item(FUNC_ENCODE, 8'h01, 1'b0);
    push_item(FUNC_DECODE, 8'h7A, 1'b1);
    push_item(FUNC_DECODE, 8'h21, 1'b0);
    push_item(FUNC_ENCODE, 8'h77, 1'b0);
    push_item(FUNC_DECODE, 8'h41, 1'b1);
    push_item(FUNC_DECODE, 8'hFF, 1'b1);
    settle();

    // zero length, then a key change in the middle of a string
    load_key(64'h0, 4'd0, 1'b0);
    push_item(FUNC_ENCODE, 8'hC3, 1'b0);
    settle();
    load_key(64'hFEDC_BA98_7654_2A00, 4'd9, 1'b0);
    push_item(FUNC_ENCODE, 8'h0F, 1'b1);

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      settle();
      case (ph)
        0: begin key = '1; len = 4'd8; sub = 1'b1; end
        1: begin key = '0; len = 4'd1; sub = 1'b0; end
        2: begin key = {$urandom, $urandom}; len = 4'd15; sub = 1'b1; end
        default: begin
          case ($urandom_range(0, 4))
            0: key = '0;
            1: key = '1;
            default: key = {$urandom, $urandom};
          endcase
          len = ($urandom_range(0, 2) == 0) ? 4'($urandom_range(0, 15))
                                            : 4'($urandom_range(1, 8));
          sub = 1'($urandom_range(0, 1));
        end
      endcase
      load_key(key, len, sub);
      src_idle = (ph < RAND_PHASES - 2) && (ph % 4 != 1);
      snk_idle = (ph < RAND_PHASES - 2) && (ph % 4 != 2);
      sent = 0;
      while (sent < PHASE_ITEMS) send_string($urandom_range(0, 9), sent);
    end
    settle();

    if (chk_fails == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
